// ===== design/bbc_pkg.sv =====
package bbc_pkg;

  // Default number of stack entries.
  localparam int unsigned BBC_STACK_DEPTH = 64;

  // Field widths on the streaming ports.
  localparam int unsigned TEXT_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NDEPTH_W = 7;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - STATUS_W - NDEPTH_W;

  // Largest nesting depth that fits the result field.
  localparam int unsigned NDEPTH_MAX = (1 << NDEPTH_W) - 1;

  // Bracket characters.
  localparam logic [TEXT_W-1:0] CH_OPEN_PAREN   = 8'h28;  // (
  localparam logic [TEXT_W-1:0] CH_CLOSE_PAREN  = 8'h29;  // )
  localparam logic [TEXT_W-1:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [TEXT_W-1:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [TEXT_W-1:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [TEXT_W-1:0] CH_CLOSE_CURLY  = 8'h7D;  // }

  // Expected-closer codes kept on the stack.
  typedef enum logic [1:0] {
    CL_PAREN  = 2'd0,
    CL_SQUARE = 2'd1,
    CL_CURLY  = 2'd2
  } bbc_closer_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_OVERFLOW = 2'd2
  } bbc_err_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING  = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_BALANCED = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_OVERFLOW = 3'd4
  } bbc_status_t;

  typedef struct packed {
    bbc_status_t         status;
    logic [NDEPTH_W-1:0] nesting_depth;
  } bbc_result_t;

endpackage

// ===== design/bbc_stack_mem.sv =====
module bbc_stack_mem #(
  parameter int unsigned DEPTH = bbc_pkg::BBC_STACK_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/bbc_ctrl.sv =====
module bbc_ctrl #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::BBC_STACK_DEPTH,
  parameter int unsigned AW          = $clog2(STACK_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_accept,
  input  logic [bbc_pkg::TEXT_W-1:0]  text_byte,
  input  logic                        is_last,
  output bbc_pkg::bbc_result_t        result,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [1:0]                  mem_wr_data,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [1:0]                  mem_rd_data
);
  import bbc_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  bbc_err_t      err_r, err_nxt;
  bbc_closer_t   top_r, top_nxt;
  logic          fwd_r;
  bbc_closer_t   fwd_data_r;

  logic          is_open, is_close;
  bbc_closer_t   open_code, close_code, below;
  logic [CW-1:0] cnt_item;
  bbc_err_t      err_item;
  logic [CW-1:0] rd_cnt;

  // Entry just under the top: the registered memory read, or the top that was
  // spilled into that very entry on the previous transfer.
  assign below = fwd_r ? fwd_data_r : bbc_closer_t'(mem_rd_data);

  always_comb begin
    is_open   = 1'b1;
    open_code = CL_PAREN;
    case (text_byte)
      CH_OPEN_PAREN:  open_code = CL_PAREN;
      CH_OPEN_SQUARE: open_code = CL_SQUARE;
      CH_OPEN_CURLY:  open_code = CL_CURLY;
      default:        is_open   = 1'b0;
    endcase
  end

  always_comb begin
    is_close   = 1'b1;
    close_code = CL_PAREN;
    case (text_byte)
      CH_CLOSE_PAREN:  close_code = CL_PAREN;
      CH_CLOSE_SQUARE: close_code = CL_SQUARE;
      CH_CLOSE_CURLY:  close_code = CL_CURLY;
      default:         is_close   = 1'b0;
    endcase
  end

  always_comb begin
    cnt_item    = count_r;
    err_item    = err_r;
    top_nxt     = top_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(count_r - CW'(1));
    mem_wr_data = top_r;

    if (item_accept && err_r == ERR_NONE) begin
      if (is_open) begin
        if (count_r == CW'(STACK_DEPTH)) begin
          err_item = ERR_OVERFLOW;
        end else begin
          // The old top moves into memory, the new closer becomes the top.
          mem_wr_en = (count_r != '0);
          top_nxt   = open_code;
          cnt_item  = count_r + CW'(1);
        end
      end else if (is_close) begin
        if (count_r == '0 || top_r != close_code) begin
          err_item = ERR_MISMATCH;
        end else begin
          top_nxt  = below;
          cnt_item = count_r - CW'(1);
        end
      end
    end

    if (err_item == ERR_OVERFLOW) begin
      result.status = ST_OVERFLOW;
    end else if (err_item == ERR_MISMATCH) begin
      result.status = ST_MISMATCH;
    end else if (is_last) begin
      result.status = (cnt_item == '0) ? ST_BALANCED : ST_UNCLOSED;
    end else begin
      result.status = ST_RUNNING;
    end
    result.nesting_depth = (32'(cnt_item) > NDEPTH_MAX) ? NDEPTH_W'(NDEPTH_MAX)
                                                        : NDEPTH_W'(cnt_item);

    count_nxt = cnt_item;
    err_nxt   = err_item;
    if (item_accept && is_last) begin
      count_nxt = '0;
      err_nxt   = ERR_NONE;
    end

    // Prefetch the entry that will sit under the top after this cycle.
    rd_cnt      = count_nxt - CW'(2);
    mem_rd_addr = AW'(rd_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ERR_NONE;
      fwd_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
      // A last byte empties the stack, so nothing needs forwarding after it.
      fwd_r   <= mem_wr_en && !(item_accept && is_last);
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    fwd_data_r <= top_r;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    item_accept && is_last |=> count_r == '0 && err_r == ERR_NONE)
    else $error("state not cleared after last byte");

  a_fwd_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> count_r >= CW'(2))
    else $error("forwarded entry without a second stack entry");

  a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_NONE && !(item_accept && is_last) |=> $stable(count_r))
    else $error("stack moved while an error was set");

endmodule

// ===== design/bbc_out_buf.sv =====
module bbc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bbc_pkg::bbc_result_t push_data,
  output logic                 not_full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bbc_pkg::bbc_result_t out_data
);
  import bbc_pkg::*;

  bbc_result_t slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  occ_r, occ_nxt;
  logic        pop;

  assign not_full  = (occ_r != 2'd2);
  assign out_valid = (occ_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (push && !pop) begin
      occ_nxt = occ_r + 2'd1;
    end else if (pop && !push) begin
      occ_nxt = occ_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/bracket_balance_checker_core.sv =====
// Bracket balance checker.
// The input stream carries one text byte per transfer in in_tdata, with
// in_tlast high on the final byte of a stream. Every input transfer produces
// exactly one output transfer: a status code and the nesting depth after the
// byte (on a last byte, the depth before the block clears itself).
// Throughput is one byte per clock cycle while the output buffer has room. The
// result of a byte is registered in the output buffer and appears on
// out_tvalid in the cycle after its transfer when the receiver is ready.
// Opening brackets push their expected closer; closing brackets are checked
// against the top of the stack. The top entry lives in a register and the
// rest of the stack in a synchronous single-write, single-read memory whose
// read is prefetched for the entry under the top, so a pop never waits.
// Errors (mismatch or overflow) are sticky until the end of the stream.
// After reset the stack is empty and no error is set; no memory clearing
// pass is needed, so the block accepts input from the first cycle.
// A two-entry output buffer separates the channels. When the receiver stalls,
// up to two results are held and in_tready drops only once both slots are full.
module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::BBC_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bbc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] text_byte
  input  logic                            in_tlast,   // is_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bbc_pkg::OUT_TDATA_W-1:0] out_tdata   // [2:0] status,
                                                      // [9:3] nesting_depth
);
  import bbc_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic          accept;
  bbc_result_t   result, out_res;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [1:0]    mem_wr_data, mem_rd_data;

  // A byte is taken whenever the output buffer has room for its result.
  assign accept = in_tvalid && in_tready;

  bbc_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (accept),
    .text_byte   (in_tdata[TEXT_W-1:0]),
    .is_last     (in_tlast),
    .result      (result),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  bbc_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bbc_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .not_full  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Status sits in the low bits, the nesting depth above it, zeros on top.
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res.nesting_depth, out_res.status};

endmodule

// ===== tb/sv/bracket_balance_checker_core_tb.sv =====
// Testbench for bracket_balance_checker_core.
//
// Text bytes are queued up front by the stimulus block as whole streams, each
// stream ending with in_tlast on its final byte. A clocked driver offers them
// on the input channel with random gaps. On every input transfer, a local
// model of the bracket stack works out the one result that the byte must
// produce and appends it to a queue. A clocked monitor takes each output
// transfer and compares it field by field against the oldest queued result.
// The receiver stalls in random bursts. Once during the run, it also holds
// off for a long stretch so that the output buffer fills and in_tready drops.
module bracket_balance_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int unsigned DEPTH        = BBC_STACK_DEPTH;
  localparam int          TARGET_ITEMS = 950;
  // Number of items before the end of the run where all idling stops.
  localparam int          CALM_ITEMS   = 100;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          HOLD_AFTER   = 300;
  // The block registers each result in its output buffer before sending it,
  // so this margin is plenty for the drain at the end.
  localparam int          DRAIN_CYCLES = 10;
  localparam int          CYCLE_LIMIT  = 100000;

  typedef struct packed {
    logic [TEXT_W-1:0] text_byte;
    logic              is_last;
  } text_item_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Bytes waiting to be offered, and the verdicts that accepted bytes owe.
  text_item_t  pending_items[$];
  bbc_result_t expected_results[$];
  // Scratch area where one stream is built before it is queued.
  logic [TEXT_W-1:0] stream_buf[$];

  // Local copy of the bracket stack, its fill level and the sticky error.
  bbc_closer_t open_stack[0:DEPTH-1];
  int          open_count = 0;
  bbc_err_t    sticky_err = ERR_NONE;

  int items_sent   = 0;
  int total_items  = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int error_count  = 0;
  int cycle_count  = 0;
  int deep_done    = 0;

  bracket_balance_checker_core #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idling is switched on and off in stretches of 64 transfers, so that runs
  // of back-to-back traffic alternate with bursty ones. It stops entirely
  // near the end of the run.
  function automatic bit idling_allowed();
    return ((items_sent / 64) % 2 == 1) && (items_sent + CALM_ITEMS < total_items);
  endfunction

  function automatic logic [TEXT_W-1:0] opener_char(bbc_closer_t c);
    case (c)
      CL_PAREN:  return CH_OPEN_PAREN;
      CL_SQUARE: return CH_OPEN_SQUARE;
      default:   return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [TEXT_W-1:0] closer_char(bbc_closer_t c);
    case (c)
      CL_PAREN:  return CH_CLOSE_PAREN;
      CL_SQUARE: return CH_CLOSE_SQUARE;
      default:   return CH_CLOSE_CURLY;
    endcase
  endfunction

  // Applies one byte to the local stack and returns the verdict the block
  // must give for it. Once an error is set, bytes are ignored until the end
  // of the stream. On a last byte, the depth reported is the depth before
  // the stack is cleared for the next stream.
  function automatic bbc_result_t predict_bracket_result(logic [TEXT_W-1:0] ch,
                                                         logic last);
    bbc_result_t verdict;
    bit          is_open  = 1'b1;
    bit          is_close = 1'b1;
    bbc_closer_t open_code  = CL_PAREN;
    bbc_closer_t close_code = CL_PAREN;

    case (ch)
      CH_OPEN_PAREN:  open_code = CL_PAREN;
      CH_OPEN_SQUARE: open_code = CL_SQUARE;
      CH_OPEN_CURLY:  open_code = CL_CURLY;
      default:        is_open = 1'b0;
    endcase
    case (ch)
      CH_CLOSE_PAREN:  close_code = CL_PAREN;
      CH_CLOSE_SQUARE: close_code = CL_SQUARE;
      CH_CLOSE_CURLY:  close_code = CL_CURLY;
      default:         is_close = 1'b0;
    endcase

    if (sticky_err == ERR_NONE) begin
      if (is_open) begin
        // A push onto a full stack is an overflow and pushes nothing.
        if (open_count >= DEPTH) begin
          sticky_err = ERR_OVERFLOW;
        end else begin
          open_stack[open_count] = open_code;
          open_count++;
        end
      end else if (is_close) begin
        // A closer on an empty stack, or one of the wrong kind, is a mismatch.
        if (open_count == 0 || open_stack[open_count-1] != close_code) begin
          sticky_err = ERR_MISMATCH;
        end else begin
          open_count--;
        end
      end
    end

    if (sticky_err == ERR_OVERFLOW) begin
      verdict.status = ST_OVERFLOW;
    end else if (sticky_err == ERR_MISMATCH) begin
      verdict.status = ST_MISMATCH;
    end else if (last) begin
      verdict.status = (open_count == 0) ? ST_BALANCED : ST_UNCLOSED;
    end else begin
      verdict.status = ST_RUNNING;
    end
    verdict.nesting_depth =
      NDEPTH_W'((open_count > NDEPTH_MAX) ? NDEPTH_MAX : open_count);

    if (last) begin
      open_count = 0;
      sticky_err = ERR_NONE;
    end
    return verdict;
  endfunction

  // Moves the bytes built in stream_buf to the pending queue and marks the
  // final one as the end of the stream.
  task automatic flush_stream();
    text_item_t item;
    while (stream_buf.size() > 0) begin
      item.text_byte = stream_buf.pop_front();
      item.is_last   = (stream_buf.size() == 0);
      pending_items.push_back(item);
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      stream_buf.push_back(s[i]);
    end
    flush_stream();
  endtask

  // A mostly well-formed stream: random nesting mixed with filler bytes. Now
  // and then a closer of the wrong kind slips in, and about one stream in
  // four ends with brackets still open.
  task automatic gen_nested();
    bbc_closer_t open_q[$];
    bbc_closer_t c;
    int          len;
    int          pick;

    len = $urandom_range(1, 24);
    repeat (len) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && open_q.size() < 12) begin
        c = bbc_closer_t'($urandom_range(0, 2));
        open_q.push_back(c);
        stream_buf.push_back(opener_char(c));
      end else if (pick < 7 && open_q.size() > 0) begin
        if ($urandom_range(0, 29) == 0) begin
          c = bbc_closer_t'((int'(open_q[open_q.size()-1]) + 1) % 3);
          stream_buf.push_back(closer_char(c));
        end else begin
          stream_buf.push_back(closer_char(open_q.pop_back()));
        end
      end else if (pick == 9 && $urandom_range(0, 7) == 0) begin
        // A stray closer, which may land on an empty stack.
        stream_buf.push_back(closer_char(bbc_closer_t'($urandom_range(0, 2))));
      end else begin
        stream_buf.push_back(TEXT_W'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      while (open_q.size() > 0) begin
        stream_buf.push_back(closer_char(open_q.pop_back()));
      end
    end
    flush_stream();
  endtask

  // Streams that reach the full stack. Variant 0 fills it exactly and closes
  // every bracket again, variant 1 pushes once more than fits and then goes
  // on with bytes that must be ignored, and variant 2 fills it and ends with
  // part of it still open.
  task automatic gen_deep(int variant);
    bbc_closer_t open_q[$];
    bbc_closer_t c;
    int          opens;
    int          closes;

    opens = (variant == 1) ? DEPTH + 1 : DEPTH;
    repeat (opens) begin
      c = bbc_closer_t'($urandom_range(0, 2));
      open_q.push_back(c);
      stream_buf.push_back(opener_char(c));
      if ($urandom_range(0, 7) == 0) begin
        stream_buf.push_back(TEXT_W'($urandom_range(0, 255)));
      end
    end
    if (variant == 1) begin
      repeat ($urandom_range(2, 6)) begin
        stream_buf.push_back(closer_char(open_q.pop_back()));
      end
    end else begin
      closes = (variant == 0) ? DEPTH : $urandom_range(1, DEPTH - 1);
      repeat (closes) begin
        stream_buf.push_back(closer_char(open_q.pop_back()));
      end
    end
    flush_stream();
  endtask

  // Driver. The byte at the head of the pending queue is offered until it is
  // taken; the expected verdict is computed in the cycle of its transfer.
  always @(posedge clk) begin : drive_proc
    text_item_t item;
    logic       nxt_valid;

    if (rst_n) begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        item = pending_items.pop_front();
        expected_results.push_back(predict_bracket_result(item.text_byte, item.is_last));
        items_sent <= items_sent + 1;
        nxt_valid = 1'b0;
        if (idling_allowed() && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 10);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          nxt_valid = 1'b1;
          item      = pending_items[0];
          in_tdata <= item.text_byte;
          in_tlast <= item.is_last;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // Receiver. After a few hundred transfers it holds off once for a long
  // stretch while the driver keeps offering bytes, so the output buffer
  // fills and the block has to stall its input. Otherwise it stalls in
  // short random bursts.
  always @(posedge clk) begin : recv_proc
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor. Every output transfer must match the oldest verdict waiting.
  always @(posedge clk) begin : check_proc
    bbc_result_t           want;
    bbc_status_t           got_status;
    logic [NDEPTH_W-1:0]   got_depth;
    logic [OUT_PAD_W-1:0]  got_pad;

    if (rst_n && out_tvalid && out_tready) begin
      got_status = bbc_status_t'(out_tdata[STATUS_W-1:0]);
      got_depth  = out_tdata[STATUS_W +: NDEPTH_W];
      got_pad    = out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W];
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual status %0d depth %0d",
                 $time, got_status, got_depth);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
          error_count++;
        end
        if (got_depth !== want.nesting_depth) begin
          $display("%0t: nesting_depth expected %0d actual %0d",
                   $time, want.nesting_depth, got_depth);
          error_count++;
        end
        if (got_pad !== '0) begin
          $display("%0t: tdata padding expected 0 actual %0h", $time, got_pad);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : limit_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bracket_balance_checker_core_tb: errors");
      $finish;
    end
  end

  initial begin : stim_proc
    int kind;

    // Directed streams: the extreme byte values, plain balanced nesting of
    // every bracket kind, a closer on an empty stack, a closer of the wrong
    // kind, an error that must stick through the last byte, and a stream
    // that ends with brackets still open.
    stream_buf.push_back(8'h00);
    flush_stream();
    stream_buf.push_back(8'hFF);
    flush_stream();
    add_text("([{}])");
    add_text("(){}[]");
    add_text("}");
    add_text("{)");
    add_text("(]x)");
    add_text("((");

    // Random streams. The three streams that reach the full stack are spread
    // over the run; any not placed by then go at the end.
    while (pending_items.size() < TARGET_ITEMS) begin
      kind = $urandom_range(0, 15);
      if (kind == 0 && deep_done < 3) begin
        gen_deep(deep_done);
        deep_done++;
      end else if (kind < 3) begin
        repeat ($urandom_range(1, 8)) begin
          stream_buf.push_back(TEXT_W'($urandom_range(0, 255)));
        end
        flush_stream();
      end else begin
        gen_nested();
      end
    end
    while (deep_done < 3) begin
      gen_deep(deep_done);
      deep_done++;
    end
    total_items = pending_items.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every byte is taken and every verdict has come back, then wait
    // out DRAIN_CYCLES so the block can show any result it should not send.
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("bracket_balance_checker_core_tb: clean");
    end else begin
      $display("bracket_balance_checker_core_tb: errors");
    end
    $finish;
  end

endmodule
